// ===== rtl/mml_pkg.sv =====
package mml_pkg;

   // Field widths
   localparam int CHAR_W = 8;
   localparam int TYPE_W = 3;
   localparam int LEN_W  = 8;
   localparam int STATE_W = 4;
   localparam int MAX_TOKEN_LEN_DEF = 255;
   localparam int LEN_LIMIT = 255;

   // Automaton states
   localparam logic [STATE_W-1:0] S_START  = 4'd0;
   localparam logic [STATE_W-1:0] S_LT     = 4'd1;
   localparam logic [STATE_W-1:0] S_EQ     = 4'd2;
   localparam logic [STATE_W-1:0] S_IDENT  = 4'd3;
   localparam logic [STATE_W-1:0] S_LIT    = 4'd4;
   localparam logic [STATE_W-1:0] S_DELIM  = 4'd5;
   localparam logic [STATE_W-1:0] S_PREFIX = 4'd6;
   localparam logic [STATE_W-1:0] S_INFIX1 = 4'd7;
   localparam logic [STATE_W-1:0] S_LE     = 4'd8;
   localparam logic [STATE_W-1:0] S_IFF    = 4'd9;
   localparam logic [STATE_W-1:0] S_IMPL   = 4'd10;
   localparam logic [STATE_W-1:0] S_TRAP   = 4'd15;

   // Token types
   localparam logic [TYPE_W-1:0] T_IDENT  = 3'd0;
   localparam logic [TYPE_W-1:0] T_LIT    = 3'd1;
   localparam logic [TYPE_W-1:0] T_DELIM  = 3'd2;
   localparam logic [TYPE_W-1:0] T_PREFIX = 3'd3;
   localparam logic [TYPE_W-1:0] T_INFIX  = 3'd4;
   localparam logic [TYPE_W-1:0] T_ERROR  = 3'd5;

   typedef struct packed {
      logic [TYPE_W-1:0] token_kind;
      logic [LEN_W-1:0]  token_length;
      logic              last;
   } token_rec_type;

   // Results of one request: count and up to two tokens
   typedef struct packed {
      logic [1:0]    count;
      token_rec_type first;
      token_rec_type second;
   } result_set_type;

   // Output queue status seen by the top level
   typedef struct packed {
      logic [1:0] fill;
   } queue_status_type;

   function automatic logic is_lower(input logic [CHAR_W-1:0] c);
      return (c >= 8'h61) && (c <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] s,
                                                  input logic [CHAR_W-1:0] c);
      logic [STATE_W-1:0] t;
      t = S_TRAP;
      case (s)
         S_LT:    t = (c == 8'h3d) ? S_LE : S_TRAP;
         S_EQ:    t = (c == 8'h3e) ? S_IMPL : S_TRAP;
         S_IDENT: t = (is_lower(c) || is_digit(c)) ? S_IDENT : S_TRAP;
         S_LE:    t = (c == 8'h3e) ? S_IFF : S_TRAP;
         S_LIT, S_DELIM, S_PREFIX, S_INFIX1, S_IFF, S_IMPL: t = S_TRAP;
         default: begin
            if (is_lower(c))                       t = S_IDENT;
            else if (c == 8'h30 || c == 8'h31)     t = S_LIT;
            else if (c == 8'h28 || c == 8'h29)     t = S_DELIM;
            else if (c == 8'h21)                   t = S_PREFIX;
            else if (c == 8'h26 || c == 8'h7c)     t = S_INFIX1;
            else if (c == 8'h3c)                   t = S_LT;
            else if (c == 8'h3d)                   t = S_EQ;
            else                                   t = S_TRAP;
         end
      endcase
      return t;
   endfunction

   function automatic logic accepting(input logic [STATE_W-1:0] s);
      return (s >= S_IDENT) && (s <= S_IMPL);
   endfunction

   function automatic logic [TYPE_W-1:0] type_of(input logic [STATE_W-1:0] s);
      logic [TYPE_W-1:0] t;
      case (s)
         S_IDENT:                       t = T_IDENT;
         S_LIT:                         t = T_LIT;
         S_DELIM:                       t = T_DELIM;
         S_PREFIX:                      t = T_PREFIX;
         S_INFIX1, S_LE, S_IFF, S_IMPL: t = T_INFIX;
         default:                       t = T_ERROR;
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/mml_if.sv =====
interface mml_req_if import mml_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ch;
   logic              end_mark;

   modport source (output valid, output ch, output end_mark, input ready);
   modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

interface mml_rsp_if import mml_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] token_kind;
   logic [LEN_W-1:0]  token_length;
   logic              last;

   modport source (output valid, output token_kind, output token_length, output last,
                   input ready);
   modport sink   (input valid, input token_kind, input token_length, input last,
                   output ready);
endinterface

// ===== rtl/mml_dfa.sv =====
module mml_dfa import mml_pkg::*; #(
   parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [CHAR_W-1:0]   ch,
   input  logic                end_mark,
   output result_set_type      results
);

   localparam int LEN_CAP_I = (MAX_TOKEN_LEN < LEN_LIMIT) ? MAX_TOKEN_LEN : LEN_LIMIT;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_I[LEN_W-1:0];

   logic [STATE_W-1:0] state_ff, state_in;
   logic [LEN_W-1:0]   run_ff, run_in;
   logic [STATE_W-1:0] cur;
   logic [STATE_W-1:0] next_s;
   logic [STATE_W-1:0] restart_s;
   logic [LEN_W-1:0]   run_inc;

   assign cur       = (state_ff > S_IMPL) ? S_START : state_ff;
   assign next_s    = advance(cur, ch);
   assign restart_s = advance(S_START, ch);
   assign run_inc   = (run_ff >= LEN_CAP) ? LEN_CAP : run_ff + 8'd1;

   // Work out the tokens and the next state for this request
   always_comb begin
      results  = '0;
      state_in = S_START;
      run_in   = '0;
      if (end_mark) begin
         if (cur != S_START) begin
            results.count = 2'd1;
            results.first = '{accepting(cur) ? type_of(cur) : T_ERROR, run_ff, 1'b1};
         end
      end else if (next_s != S_TRAP) begin
         state_in = next_s;
         run_in   = run_inc;
      end else if (!accepting(cur)) begin
         results.count = 2'd1;
         results.first = '{T_ERROR, run_inc, 1'b1};
      end else if (restart_s != S_TRAP) begin
         results.count = 2'd1;
         results.first = '{type_of(cur), run_ff, 1'b1};
         state_in      = restart_s;
         run_in        = 8'd1;
      end else begin
         results.count  = 2'd2;
         results.first  = '{type_of(cur), run_ff, 1'b0};
         results.second = '{T_ERROR, 8'd1, 1'b1};
      end
   end

   // Advance the automaton on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         run_ff   <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         run_ff   <= run_in;
      end
   end

endmodule

// ===== rtl/mml_obuf.sv =====
module mml_obuf import mml_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  result_set_type    results,
   input  logic              pop,
   output logic              ready,
   output logic              out_valid,
   output token_rec_type     head,
   output queue_status_type  status
);

   token_rec_type    slot_ff [3];
   token_rec_type    slot_in [3];
   logic [1:0]       fill_ff, fill_in;
   logic [1:0]       kept;
   logic [1:0]       added;
   token_rec_type    shift0;
   token_rec_type    shift1;

   // Take a request only when both of its possible tokens fit
   assign ready     = (fill_ff <= 2'd1) || ((fill_ff == 2'd2) && pop);
   assign out_valid = (fill_ff != 2'd0);
   assign head      = slot_ff[0];
   assign status.fill = fill_ff;

   // Drop the head on a pop, then append new tokens behind what is left
   always_comb begin
      kept    = fill_ff - {1'b0, pop};
      added   = push ? results.count : 2'd0;
      shift0  = pop ? slot_ff[1] : slot_ff[0];
      shift1  = pop ? slot_ff[2] : slot_ff[1];
      slot_in[0] = (kept == 2'd0) ? results.first : shift0;
      slot_in[1] = (kept == 2'd0) ? results.second :
                   (kept == 2'd1) ? results.first : shift1;
      slot_in[2] = (kept == 2'd1) ? results.second :
                   (kept == 2'd2) ? results.first : slot_ff[2];
      fill_in = kept + added;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      slot_ff[2] <= slot_in[2];
   end

endmodule

// ===== rtl/maximal_munch_logic_lexer.sv =====
// A request's tokens are formed combinationally and registered into the result queue,
// each offered at its head. Throughput: one request a cycle; the result side moves one
// token a cycle while the receiver is ready, and a request is held off only while the
// three-entry result queue lacks room for two tokens, so a single waiting token does not stall requests.
// Reset: synchronous, active high; automaton to the start state, queue emptied.
module maximal_munch_logic_lexer import mml_pkg::*; #(
   parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   mml_req_if.sink      req_chan,
   mml_rsp_if.source    rsp_chan
);

   result_set_type   results;
   token_rec_type    head;
   queue_status_type status;
   logic             req_ready;
   logic             fire;
   logic             pop;

   assign fire = req_chan.valid && req_ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = req_ready;

   mml_dfa #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_dfa (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .ch       (req_chan.ch),
      .end_mark (req_chan.end_mark),
      .results  (results)
   );

   mml_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .results   (results),
      .pop       (pop),
      .ready     (req_ready),
      .out_valid (rsp_chan.valid),
      .head      (head),
      .status    (status)
   );

   assign rsp_chan.token_kind   = head.token_kind;
   assign rsp_chan.token_length = head.token_length;
   assign rsp_chan.last         = head.last;

`ifndef ASSERT_OFF
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      status.fill == 2'd3 |-> !req_ready) else $error("request taken into a full queue");

   a_pair_shape: assert property (@(posedge clock) disable iff (reset)
      results.count == 2'd2 |-> !results.first.last && results.second.last
         && results.second.token_kind == T_ERROR) else $error("bad token pair");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      results.count == 2'd1 |-> results.first.last) else $error("single token not last");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      status.fill == 2'd1 && pop && !fire |=> status.fill == 2'd0)
      else $error("queue did not drain");
`endif

endmodule

// ===== dv/tb_maximal_munch_logic_lexer.sv =====
module tb_maximal_munch_logic_lexer;
   timeunit 1ns;
   timeprecision 1ps;
   import mml_pkg::*;

   localparam int LEN_CAP = (MAX_TOKEN_LEN_DEF < 255) ? MAX_TOKEN_LEN_DEF : 255;
   localparam int RANDOM_ITEMS = 1300;

   // Track the lexer state and the tokens still owed by the block
   class token_ledger;
      logic [STATE_W-1:0] dfa_state;
      logic [LEN_W-1:0]   run_len;
      token_rec_type      awaited_tokens[$];
      int unsigned        errors;

      function new();
         restart();
         errors = 0;
      endfunction

      function void restart();
         dfa_state = S_START;
         run_len   = '0;
      endfunction

      function logic [STATE_W-1:0] follow(input logic [STATE_W-1:0] s,
                                          input logic [CHAR_W-1:0] c);
         logic lower;
         logic digit;
         lower = (c >= "a") && (c <= "z");
         digit = (c >= "0") && (c <= "9");
         case (s)
            S_LT:    return (c == "=") ? S_LE : S_TRAP;
            S_EQ:    return (c == ">") ? S_IMPL : S_TRAP;
            S_IDENT: return (lower || digit) ? S_IDENT : S_TRAP;
            S_LE:    return (c == ">") ? S_IFF : S_TRAP;
            S_LIT, S_DELIM, S_PREFIX, S_INFIX1, S_IFF, S_IMPL: return S_TRAP;
            default: ;
         endcase
         // start state: open a new token
         if (lower)                     return S_IDENT;
         if (c == "0" || c == "1")      return S_LIT;
         if (c == "(" || c == ")")      return S_DELIM;
         if (c == "!")                  return S_PREFIX;
         if (c == "&" || c == "|")      return S_INFIX1;
         if (c == "<")                  return S_LT;
         if (c == "=")                  return S_EQ;
         return S_TRAP;
      endfunction

      function bit accepts(input logic [STATE_W-1:0] s);
         return (s >= S_IDENT) && (s <= S_IMPL);
      endfunction

      function logic [TYPE_W-1:0] kind_of(input logic [STATE_W-1:0] s);
         case (s)
            S_IDENT:                       return T_IDENT;
            S_LIT:                         return T_LIT;
            S_DELIM:                       return T_DELIM;
            S_PREFIX:                      return T_PREFIX;
            S_INFIX1, S_LE, S_IFF, S_IMPL: return T_INFIX;
            default:                       return T_ERROR;
         endcase
      endfunction

      function logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] n);
         return (n >= LEN_CAP) ? LEN_W'(LEN_CAP) : n + 8'd1;
      endfunction

      function void push_token(input logic [TYPE_W-1:0] kind, input logic [LEN_W-1:0] len,
                               input logic fin);
         token_rec_type tok;
         tok.token_kind   = kind;
         tok.token_length = len;
         tok.last         = fin;
         awaited_tokens.push_back(tok);
      endfunction

      // Work out the tokens that one accepted request causes
      function void note_request(input logic [CHAR_W-1:0] c, input logic fin);
         logic [STATE_W-1:0] s;
         logic [STATE_W-1:0] t;
         s = (dfa_state > S_IMPL) ? S_START : dfa_state;
         if (fin) begin
            if (accepts(s))
               push_token(kind_of(s), run_len, 1'b1);
            else if (s != S_START)
               push_token(T_ERROR, run_len, 1'b1);
            restart();
            return;
         end
         t = follow(s, c);
         if (t != S_TRAP) begin
            dfa_state = t;
            run_len   = bump(run_len);
            return;
         end
         // failure before any token was accepted
         if (!accepts(s)) begin
            push_token(T_ERROR, bump(run_len), 1'b1);
            restart();
            return;
         end
         // emit the accepted token and relex the character from the start
         t = follow(S_START, c);
         if (t != S_TRAP) begin
            push_token(kind_of(s), run_len, 1'b1);
            dfa_state = t;
            run_len   = 8'd1;
            return;
         end
         push_token(kind_of(s), run_len, 1'b0);
         push_token(T_ERROR, 8'd1, 1'b1);
         restart();
      endfunction

      function void check_token(input logic [TYPE_W-1:0] kind, input logic [LEN_W-1:0] len,
                                input logic fin);
         token_rec_type want;
         if (awaited_tokens.size() == 0) begin
            errors++;
            $display("%0t: token with none awaited: type %0d length %0d last %0b",
                     $time, kind, len, fin);
            return;
         end
         want = awaited_tokens.pop_front();
         if (kind !== want.token_kind) begin
            errors++;
            $display("%0t: token_kind expected %0d actual %0d", $time, want.token_kind, kind);
         end
         if (len !== want.token_length) begin
            errors++;
            $display("%0t: token_length expected %0d actual %0d",
                     $time, want.token_length, len);
         end
         if (fin !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, fin);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   mml_req_if req_chan ();
   mml_rsp_if rsp_chan ();

   maximal_munch_logic_lexer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   token_ledger lex = new();
   bit          send_calm;
   int unsigned items_sent;
   int unsigned tokens_seen;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic offer(input logic [CHAR_W-1:0] c, input logic fin);
      int unsigned gap;
      gap = send_calm ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid    = 1'b0;
         req_chan.ch       = 8'($urandom_range(0, 255));
         req_chan.end_mark = 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      req_chan.valid    = 1'b1;
      req_chan.ch       = c;
      req_chan.end_mark = fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      lex.note_request(c, fin);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         offer(s[i], 1'b0);
   endtask

   task automatic send_ident(input int unsigned len);
      int unsigned r;
      offer(8'("a") + 8'($urandom_range(0, 25)), 1'b0);
      for (int unsigned i = 1; i < len; i++) begin
         r = $urandom_range(0, 35);
         offer((r < 26) ? 8'("a") + 8'(r) : 8'("0") + 8'(r - 26), 1'b0);
      end
   endtask

   // Mostly well-formed tokens with random content, some noise and broken ones
   task automatic send_random_token();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)
         send_ident(($urandom_range(0, 49) == 0) ? $urandom_range(250, 270)
                                                 : $urandom_range(1, 8));
      else if (r < 42)
         offer(8'("0") + 8'($urandom_range(0, 1)), 1'b0);
      else if (r < 52)
         offer($urandom_range(0, 1) ? 8'("(") : 8'(")"), 1'b0);
      else if (r < 58)
         offer("!", 1'b0);
      else if (r < 68)
         offer($urandom_range(0, 1) ? 8'("&") : 8'("|"), 1'b0);
      else if (r < 76)
         case ($urandom_range(0, 2))
            0:       send_text("<=");
            1:       send_text("<=>");
            default: send_text("=>");
         endcase
      else if (r < 82)
         offer(8'($urandom_range(0, 255)), 1'b1);
      else if (r < 88)
         offer($urandom_range(0, 1) ? 8'("<") : 8'("="), 1'b0);
      else
         offer(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Stimulus
   initial begin
      req_chan.valid    = 1'b0;
      req_chan.ch       = '0;
      req_chan.end_mark = 1'b0;
      reset             = 1'b1;
      send_calm         = 1'b0;
      items_sent        = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identifier over the alphabet extremes, flushed by the end marker
      send_text("az09");
      offer(8'h00, 1'b1);
      // every token class, infix forms breaking one another, an identifier
      // broken by a bad character, a failing partial operator, a lone '='
      // flushed, and the end marker with nothing pending
      send_text("01()!&|<=>=><=x#<#=");
      offer(8'hff, 1'b1);
      offer(8'h00, 1'b1);
      offer(8'h00, 1'b0);
      offer(8'hff, 1'b0);

      // saturate the run length once, then random traffic
      items_sent = 0;
      send_ident($urandom_range(256, 300));
      while (items_sent < RANDOM_ITEMS) begin
         send_calm = ($urandom_range(0, 7) == 0);
         send_random_token();
      end
      send_calm = 1'b0;
      offer(8'h00, 1'b1);
      @(negedge clock);
      req_chan.valid = 1'b0;

      // drain and let the block settle
      while (lex.awaited_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (lex.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Result side: random stalls, calm stretches and two long hold-offs
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned calm_left;
      bit          calm;
      stall_left     = 0;
      hold_left      = 0;
      calm_left      = 0;
      calm           = 1'b0;
      tokens_seen    = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 100);
         end else begin
            calm_left--;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0 && !calm) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            stall_left     = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
         end
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            lex.check_token(rsp_chan.token_kind, rsp_chan.token_length, rsp_chan.last);
            tokens_seen++;
            // hold off long enough to fill the result queue and stall requests
            if (tokens_seen == 40 || tokens_seen == 400)
               hold_left = 80;
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
